### rtl/core/bfb_pkg.sv
// Package for the board frame builder: shared constants, the command
// record passed from the front part to the back part, and step indexes.
// No dependencies.
package bfb_pkg;

   localparam int LenWidth = 13;
   localparam logic [LenWidth-1:0] MaxPayload = 13'd4096;
   localparam logic [LenWidth-1:0] HeaderLenAdd = 13'd10;

   localparam logic [7:0] SyncByte0 = 8'hEB;
   localparam logic [7:0] SyncByte1 = 8'hA0;
   localparam logic [7:0] SyncByte2 = 8'hF9;
   localparam logic [7:0] ReservedByte = 8'h00;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam int HeaderBytes = 17;
   localparam int StepWidth = 5;
   localparam logic [StepWidth-1:0] StepFirst = 5'd0;
   localparam logic [StepWidth-1:0] StepSeqLo = 5'd3;
   localparam logic [StepWidth-1:0] StepLastHeader = 5'd16;
   localparam logic [StepWidth-1:0] StepData = 5'd17;
   localparam logic [StepWidth-1:0] StepCheck = 5'd18;

   typedef struct packed {
      logic                start;
      logic                has_data;
      logic                last;
      logic [15:0]         seq;
      logic [LenWidth-1:0] flen;
      logic [7:0]          chan;
      logic [15:0]         slot;
      logic [7:0]          link;
      logic [15:0]         freq;
      logic [15:0]         att;
      logic [7:0]          data;
   } cmd_type;

endpackage

### rtl/core/bfb_if.sv
// Handshake channels of the board frame builder: the request channel that
// carries payload items and the response channel that carries frame bytes.
// No dependencies.
interface bfb_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         phy_channel;
   logic [15:0]        first_slot;
   logic [7:0]         link_id;
   logic signed [15:0] freq_offset;
   logic [15:0]        attenuation;
   logic [12:0]        payload_len;
   logic [7:0]         data_byte;

   modport source (output valid, phy_channel, first_slot, link_id, freq_offset,
                   attenuation, payload_len, data_byte, input ready);
   modport sink (input valid, phy_channel, first_slot, link_id, freq_offset,
                 attenuation, payload_len, data_byte, output ready);
endinterface

interface bfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

### rtl/core/bfb_front.sv
// Front part of the board frame builder: accepts request transfers, tracks
// frame position and sequence number, and issues one command per item.
// Depends on bfb_pkg and bfb_if.
module bfb_front
   import bfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bfb_req_if.sink   req,
   input  logic      queue_full,
   output logic      push,
   output cmd_type   push_cmd
);

   logic                inside_ff, inside_in;
   logic [LenWidth-1:0] rem_ff, rem_in;
   logic [15:0]         seq_ff, seq_in;
   logic [LenWidth-1:0] plen;

   assign req.ready = !queue_full;
   assign push = req.valid && !queue_full;

   always_comb begin
      plen = (req.payload_len > MaxPayload) ? MaxPayload : req.payload_len;
      inside_in = inside_ff;
      rem_in = rem_ff;
      seq_in = seq_ff;
      push_cmd.start = !inside_ff;
      push_cmd.seq = seq_ff;
      push_cmd.flen = plen + HeaderLenAdd;
      push_cmd.chan = req.phy_channel;
      push_cmd.slot = req.first_slot;
      push_cmd.link = req.link_id;
      push_cmd.freq = req.freq_offset;
      push_cmd.att = req.attenuation;
      push_cmd.data = req.data_byte;
      if (inside_ff) begin
         push_cmd.has_data = 1'b1;
         push_cmd.last = (rem_ff == LenWidth'(1));
      end else begin
         push_cmd.has_data = (plen != '0);
         push_cmd.last = (plen == '0) || (plen == LenWidth'(1));
      end
      if (push) begin
         if (inside_ff) begin
            rem_in = rem_ff - LenWidth'(1);
            inside_in = (rem_ff != LenWidth'(1));
         end else begin
            seq_in = seq_ff + 16'd1;
            if (plen != '0) begin
               rem_in = plen - LenWidth'(1);
               inside_in = (plen != LenWidth'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         rem_ff <= '0;
         seq_ff <= '0;
      end else begin
         inside_ff <= inside_in;
         rem_ff <= rem_in;
         seq_ff <= seq_in;
      end
   end

endmodule

### rtl/core/bfb_queue.sv
// Command queue between the front and back parts of the board frame builder.
// QueueDepth register entries with read and write pointers.
// Depends on bfb_pkg.
module bfb_queue
   import bfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   cmd_type                  mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign full = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrWidth'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/bfb_back.sv
// Back part of the board frame builder: steps through the bytes of each
// command (header, payload byte, checksum) into a registered response stage.
// Depends on bfb_pkg and bfb_if.
module bfb_back
   import bfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head_cmd,
   input  logic    empty,
   output logic    pop,
   bfb_rsp_if.source rsp
);

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic                 mid_ff, mid_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [7:0]           sum_ff, sum_in;
   logic [StepWidth-1:0] step_cur;
   logic [StepWidth-1:0] step_next;
   logic [7:0]           hdr [HeaderBytes];
   logic [7:0]           byte_sel;
   logic                 advance;
   logic                 done;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.frame_byte = rsp_byte_ff;
   assign rsp.frame_end = rsp_end_ff;

   always_comb begin
      hdr[0] = SyncByte0;
      hdr[1] = SyncByte1;
      hdr[2] = SyncByte2;
      hdr[3] = head_cmd.seq[7:0];
      hdr[4] = head_cmd.seq[15:8];
      hdr[5] = head_cmd.flen[7:0];
      hdr[6] = {3'b000, head_cmd.flen[12:8]};
      hdr[7] = head_cmd.chan;
      hdr[8] = head_cmd.slot[7:0];
      hdr[9] = head_cmd.slot[15:8];
      hdr[10] = ReservedByte;
      hdr[11] = ReservedByte;
      hdr[12] = head_cmd.link;
      hdr[13] = head_cmd.freq[7:0];
      hdr[14] = head_cmd.freq[15:8];
      hdr[15] = head_cmd.att[7:0];
      hdr[16] = head_cmd.att[15:8];
   end

   always_comb begin
      advance = !empty && (!rsp_valid_ff || rsp.ready);
      if (mid_ff) begin
         step_cur = step_ff;
      end else begin
         step_cur = head_cmd.start ? StepFirst : StepData;
      end
      if (step_cur <= StepLastHeader) begin
         byte_sel = hdr[step_cur];
      end else if (step_cur == StepData) begin
         byte_sel = head_cmd.data;
      end else begin
         byte_sel = sum_ff;
      end
      if (step_cur == StepLastHeader) begin
         step_next = head_cmd.has_data ? StepData : StepCheck;
      end else begin
         step_next = step_cur + StepWidth'(1);
      end
      done = (step_cur == StepCheck) || ((step_cur == StepData) && !head_cmd.last);
      pop = advance && done;

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_end_in = rsp_end_ff;
      mid_in = mid_ff;
      step_in = step_ff;
      sum_in = sum_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in = byte_sel;
         rsp_end_in = (step_cur == StepCheck);
         mid_in = !done;
         step_in = step_next;
         if (step_cur >= StepSeqLo && step_cur <= StepData) begin
            sum_in = ((step_cur == StepSeqLo) ? 8'd0 : sum_ff) + byte_sel;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mid_ff <= 1'b0;
         step_ff <= '0;
         sum_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mid_ff <= mid_in;
         step_ff <= step_in;
         sum_ff <= sum_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff <= rsp_end_in;
   end

   a_mid_has_cmd: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> !empty)
      else $error("Back part is inside a command but the queue is empty.");

   a_mid_step_range: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> (step_ff != StepFirst && step_ff <= StepCheck))
      else $error("Back part step index out of range.");

   a_check_on_last: assert property (@(posedge clock) disable iff (reset)
      (advance && step_cur == StepCheck) |-> head_cmd.last)
      else $error("Checksum emitted for a command that does not end a frame.");

   a_end_pops: assert property (@(posedge clock) disable iff (reset)
      (advance && step_cur == StepCheck) |=> (!mid_ff && rsp_end_ff))
      else $error("Frame end transfer did not close the command.");

endmodule

### rtl/core/board_frame_builder.sv
// Board frame builder: a request accepted into an empty design reaches the
// response port through the command queue and the registered response stage.
// A payload item takes one response byte, so items stream one per cycle while
// the receiver is ready; a frame with N payload bytes has N + 18 response bytes,
// an empty one 18. The back part emitting one byte per cycle sets this rate.
// Synchronous reset clears the sequence number, frame state and queue.
module board_frame_builder
   import bfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bfb_req_if.sink   req,
   bfb_rsp_if.source rsp
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   cmd_type head_cmd;
   logic    empty;

   bfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   bfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty)
   );

   bfb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .empty    (empty),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

### tb/tb_board_frame_builder.sv
// Testbench for board_frame_builder: drives payload items through phases of
// sender idling and receiver stalls, and checks every frame byte in order.
// Depends on bfb_pkg and the bfb_req_if and bfb_rsp_if interfaces.
module tb_board_frame_builder
   import bfb_pkg::*;
();

   localparam int IdleLimit = 2000;
   localparam int PhaseItems = 80;
   localparam int TailCycles = 20;

   typedef struct packed {
      logic [7:0]         phy_channel;
      logic [15:0]        first_slot;
      logic [7:0]         link_id;
      logic signed [15:0] freq_offset;
      logic [15:0]        attenuation;
      logic [12:0]        payload_len;
      logic [7:0]         data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_out_type;

   class frame_tracker_type;
      logic [15:0]   seq_num;
      bit            in_frame;
      logic [12:0]   remaining;
      logic [7:0]    sum;
      frame_out_type bytes_due[$];
      int            errors;

      function new();
         seq_num = '0;
         in_frame = 1'b0;
         remaining = '0;
         sum = '0;
         errors = 0;
      endfunction

      function void push_byte(logic [7:0] value, logic last, bit summed);
         frame_out_type b;
         b.value = value;
         b.last = last;
         if (summed) begin
            sum = sum + value;
         end
         bytes_due.insert(bytes_due.size(), b);
      endfunction

      function void note_request(req_item_type it);
         logic [12:0] plen;
         logic [15:0] flen;
         if (!in_frame) begin
            plen = (it.payload_len > MaxPayload) ? MaxPayload : it.payload_len;
            flen = 16'(plen) + 16'd10;
            sum = '0;
            push_byte(8'hEB, 1'b0, 1'b0);
            push_byte(8'hA0, 1'b0, 1'b0);
            push_byte(8'hF9, 1'b0, 1'b0);
            push_byte(seq_num[7:0], 1'b0, 1'b1);
            push_byte(seq_num[15:8], 1'b0, 1'b1);
            push_byte(flen[7:0], 1'b0, 1'b1);
            push_byte(flen[15:8], 1'b0, 1'b1);
            push_byte(it.phy_channel, 1'b0, 1'b1);
            push_byte(it.first_slot[7:0], 1'b0, 1'b1);
            push_byte(it.first_slot[15:8], 1'b0, 1'b1);
            push_byte(8'h00, 1'b0, 1'b1);
            push_byte(8'h00, 1'b0, 1'b1);
            push_byte(it.link_id, 1'b0, 1'b1);
            push_byte(it.freq_offset[7:0], 1'b0, 1'b1);
            push_byte(it.freq_offset[15:8], 1'b0, 1'b1);
            push_byte(it.attenuation[7:0], 1'b0, 1'b1);
            push_byte(it.attenuation[15:8], 1'b0, 1'b1);
            seq_num = seq_num + 16'd1;
            if (plen == '0) begin
               push_byte(sum, 1'b1, 1'b0);
               sum = '0;
               return;
            end
            remaining = plen;
            in_frame = 1'b1;
         end
         push_byte(it.data_byte, 1'b0, 1'b1);
         if (remaining != '0) begin
            remaining = remaining - 13'd1;
         end
         if (remaining == '0) begin
            push_byte(sum, 1'b1, 1'b0);
            in_frame = 1'b0;
            sum = '0;
         end
      endfunction

      function void check_byte(logic [7:0] value, logic last);
         frame_out_type want;
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected frame byte %02h end %0b", $time, value, last);
            errors++;
            return;
         end
         want = bytes_due.pop_front();
         if (value !== want.value || last !== want.last) begin
            $display("%0t: frame byte mismatch, expected %02h end %0b, actual %02h end %0b",
                     $time, want.value, want.last, value, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   item_count;
   int   quiet_cycles;
   frame_tracker_type board;

   bfb_req_if req ();
   bfb_rsp_if rsp ();

   board_frame_builder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      req_item_type seen;
      if (!reset) begin
         if (req.valid && req.ready) begin
            seen.phy_channel = req.phy_channel;
            seen.first_slot = req.first_slot;
            seen.link_id = req.link_id;
            seen.freq_offset = req.freq_offset;
            seen.attenuation = req.attenuation;
            seen.payload_len = req.payload_len;
            seen.data_byte = req.data_byte;
            board.note_request(seen);
         end
         if (rsp.valid && rsp.ready) begin
            board.check_byte(rsp.frame_byte, rsp.frame_end);
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IdleLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic req_item_type random_item(logic [12:0] plen);
      req_item_type it;
      it.phy_channel = 8'($urandom);
      it.first_slot = 16'($urandom);
      it.link_id = 8'($urandom);
      it.freq_offset = 16'($urandom);
      it.attenuation = 16'($urandom);
      it.payload_len = plen;
      it.data_byte = 8'($urandom);
      return it;
   endfunction

   function automatic logic [12:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         return 13'd0;
      end else if (r < 85) begin
         return 13'($urandom_range(1, 8));
      end else if (r < 97) begin
         return 13'($urandom_range(9, 40));
      end
      return 13'($urandom_range(41, 200));
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.phy_channel <= it.phy_channel;
      req.first_slot <= it.first_slot;
      req.link_id <= it.link_id;
      req.freq_offset <= it.freq_offset;
      req.attenuation <= it.attenuation;
      req.payload_len <= it.payload_len;
      req.data_byte <= it.data_byte;
      do @(posedge clock); while (!req.ready);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_frame(input req_item_type head);
      int count;
      count = (head.payload_len > MaxPayload) ? int'(MaxPayload) : int'(head.payload_len);
      send_item(head);
      for (int i = 1; i < count; i++) begin
         send_item(random_item(13'($urandom)));
      end
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.bytes_due.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   initial begin
      req_item_type it;
      int           phase_start;
      board = new();
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      item_count = 0;
      quiet_cycles = 0;
      req.valid = 1'b0;
      req.phy_channel = '0;
      req.first_slot = '0;
      req.link_id = '0;
      req.freq_offset = '0;
      req.attenuation = '0;
      req.payload_len = '0;
      req.data_byte = '0;
      rsp.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty and one-byte frames with all header fields at their lowest and highest values.
      it = '0;
      it.data_byte = 8'hFF;
      send_item(it);
      it.phy_channel = 8'hFF;
      it.first_slot = 16'hFFFF;
      it.link_id = 8'hFF;
      it.freq_offset = 16'sh7FFF;
      it.attenuation = 16'hFFFF;
      it.data_byte = 8'h00;
      send_item(it);
      it = random_item(13'd1);
      it.freq_offset = 16'sh8000;
      it.data_byte = 8'h00;
      send_item(it);
      it = random_item(13'd1);
      it.data_byte = 8'hFF;
      send_item(it);
      // Inside a frame every field but the data byte must be ignored.
      send_item(random_item(13'd2));
      it = '1;
      send_item(it);
      send_item(random_item(13'd5));
      for (int i = 0; i < 4; i++) begin
         it = random_item(13'(i * 1000));
         it.data_byte = (i % 2 == 0) ? 8'h00 : 8'hFF;
         send_item(it);
      end
      send_item(random_item(13'd0));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 75;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 75;
            end
            default: begin
               send_idle_pct = 27;
               recv_stall_pct = 27;
            end
         endcase
         phase_start = item_count;
         while (item_count - phase_start < PhaseItems) begin
            send_frame(random_item(pick_len()));
         end
         wait_drained();
      end

      repeat (TailCycles) @(posedge clock);
      if (board.errors == 0 && board.bytes_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
